// File: src/crast_pkg.sv
// Shared widths, codes and structs for the circle rasteriser.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package crast_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int OUT_BITS    = COORD_BITS + 1;
    localparam int OFS_BITS    = RADIUS_BITS + 1;
    localparam int DEC_BITS    = RADIUS_BITS + 2;
    localparam int DCALC_BITS  = RADIUS_BITS + 3;
    localparam int CALC_BITS   = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 1;
    localparam int COLOR_BITS  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int IDX_BITS    = 3;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    localparam logic [IDX_BITS-1:0] LAST_FILLED  = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] LAST_OUTLINE = IDX_BITS'(7);

    // One loop iteration, as handed from the front to the back.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFS_BITS-1:0]   ox;
        logic signed [OFS_BITS-1:0]   oy;
        logic                         filled;
        logic [COLOR_BITS-1:0]        color;
        logic                         done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/crast_front.sv
// Front end: takes load and step transfers, holds the circle and runs the
// decision update, then pushes one job per step while busy. Depends on crast_pkg.
`timescale 1ns / 1ps

module crast_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_action,
    input  logic signed [crast_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic signed [crast_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic [crast_pkg::RADIUS_BITS-1:0]    i_radius,
    input  logic                                 i_filled,
    input  logic [crast_pkg::COLOR_BITS-1:0]     i_color,
    output logic                                 o_push,
    output crast_pkg::t_job                      o_job
);
    import crast_pkg::*;

    logic                          r_busy, n_busy;
    logic signed [COORD_BITS-1:0]  r_cx, n_cx;
    logic signed [COORD_BITS-1:0]  r_cy, n_cy;
    logic [RADIUS_BITS-1:0]        r_r, n_r;
    logic                          r_filled, n_filled;
    logic [COLOR_BITS-1:0]         r_color, n_color;
    logic signed [OFS_BITS-1:0]    r_x, n_x;
    logic signed [OFS_BITS-1:0]    r_y, n_y;
    logic signed [DEC_BITS-1:0]    r_d, n_d;

    logic signed [DCALC_BITS-1:0]  d_ext, x_ext, y_ext, r_ext;
    logic signed [DCALC_BITS-1:0]  upd_d;
    logic signed [OFS_BITS-1:0]    upd_x, upd_y;
    logic                          upd_done;

    // Three-way decision rule of the scheme.
    always_comb begin
        d_ext = DCALC_BITS'(r_d);
        x_ext = DCALC_BITS'(r_x);
        y_ext = DCALC_BITS'(r_y);
        r_ext = $signed(DCALC_BITS'(r_r));
        upd_x = r_x;
        upd_y = r_y;
        priority if (d_ext >= x_ext + x_ext) begin
            upd_d = d_ext - (x_ext + x_ext) - DCALC_BITS'(1);
            upd_x = r_x + OFS_BITS'(1);
        end else if (d_ext < (r_ext - y_ext) + (r_ext - y_ext)) begin
            upd_d = d_ext + (y_ext + y_ext) - DCALC_BITS'(1);
            upd_y = r_y - OFS_BITS'(1);
        end else begin
            upd_d = d_ext + ((y_ext - x_ext - DCALC_BITS'(1)) <<< 1);
            upd_x = r_x + OFS_BITS'(1);
            upd_y = r_y - OFS_BITS'(1);
        end
        upd_done = (upd_y < upd_x);
    end

    assign o_push = i_accept && (t_action'(i_action) == ACT_STEP) && r_busy;

    always_comb begin
        o_job.cx     = r_cx;
        o_job.cy     = r_cy;
        o_job.ox     = r_x;
        o_job.oy     = r_y;
        o_job.filled = r_filled;
        o_job.color  = r_color;
        o_job.done   = upd_done;
    end

    always_comb begin
        n_busy   = r_busy;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_r      = r_r;
        n_filled = r_filled;
        n_color  = r_color;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        if (i_accept && (t_action'(i_action) == ACT_LOAD)) begin
            n_busy   = 1'b1;
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_r      = i_radius;
            n_filled = i_filled;
            n_color  = i_color;
            n_x      = '0;
            n_y      = $signed(OFS_BITS'(i_radius));
            n_d      = $signed(DEC_BITS'(i_radius)) - DEC_BITS'(1);
        end else if (o_push) begin
            n_busy = !upd_done;
            n_x    = upd_x;
            n_y    = upd_y;
            n_d    = DEC_BITS'(upd_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_r      <= '0;
            r_filled <= 1'b0;
            r_color  <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
        end else begin
            r_busy   <= n_busy;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_r      <= n_r;
            r_filled <= n_filled;
            r_color  <= n_color;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
        end
    end

endmodule

// File: src/crast_queue.sv
// Short job queue between the front and back ends, built from flip-flops.
// Depends on crast_pkg for the job type and depth.
`timescale 1ns / 1ps

module crast_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crast_pkg::t_job    i_job,
    input  logic               i_pop,
    output crast_pkg::t_job    o_job,
    output crast_pkg::t_q_stat o_stat
);
    import crast_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;

    function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] q;
        q = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
        return q;
    endfunction

    assign o_stat.full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? bump(r_wr) : r_wr;
        n_rd  = i_pop ? bump(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: src/crast_back.sv
// Back end: expands one job into its four spans or eight points, one per
// cycle unless stalled, into a registered output stage. Depends on crast_pkg.
`timescale 1ns / 1ps

module crast_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  crast_pkg::t_job                     i_job,
    input  crast_pkg::t_q_stat                  i_stat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_x_start,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_x_end,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_y,
    output logic [crast_pkg::COLOR_BITS-1:0]    o_pixel_color,
    output logic                                o_last_of_step,
    output logic                                o_circle_done
);
    import crast_pkg::*;

    t_job                 r_job, n_job;
    logic                 r_active, n_active;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic                 r_ovalid, n_ovalid;
    logic signed [OUT_BITS-1:0] r_xs, r_xe, r_y;
    logic [COLOR_BITS-1:0] r_color;
    logic                 r_last, r_done;

    logic signed [CALC_BITS-1:0] cx, cy, ox, oy;
    logic signed [OUT_BITS-1:0]  cx_p_ox, cx_m_ox, cx_p_oy, cx_m_oy;
    logic signed [OUT_BITS-1:0]  cy_p_ox, cy_m_ox, cy_p_oy, cy_m_oy;
    logic signed [OUT_BITS-1:0]  s_xs, s_xe, s_y;
    logic                        s_last;
    logic                        out_load, emit;

    always_comb begin
        cx = CALC_BITS'(r_job.cx);
        cy = CALC_BITS'(r_job.cy);
        ox = CALC_BITS'(r_job.ox);
        oy = CALC_BITS'(r_job.oy);
        cx_p_ox = OUT_BITS'(cx + ox);
        cx_m_ox = OUT_BITS'(cx - ox);
        cx_p_oy = OUT_BITS'(cx + oy);
        cx_m_oy = OUT_BITS'(cx - oy);
        cy_p_ox = OUT_BITS'(cy + ox);
        cy_m_ox = OUT_BITS'(cy - ox);
        cy_p_oy = OUT_BITS'(cy + oy);
        cy_m_oy = OUT_BITS'(cy - oy);
    end

    // Result selection for the current index; filled spans use only 0..3.
    always_comb begin
        s_xs = cx_p_ox;
        s_xe = cx_p_ox;
        s_y  = cy_p_oy;
        if (r_job.filled) begin
            s_last = (r_idx == LAST_FILLED);
            unique case (r_idx[1:0])
                2'd0: begin s_xs = cx_m_oy; s_xe = cx_p_oy; s_y = cy_p_ox; end
                2'd1: begin s_xs = cx_m_ox; s_xe = cx_p_ox; s_y = cy_p_oy; end
                2'd2: begin s_xs = cx_m_ox; s_xe = cx_p_ox; s_y = cy_m_oy; end
                default: begin s_xs = cx_m_oy; s_xe = cx_p_oy; s_y = cy_m_ox; end
            endcase
        end else begin
            s_last = (r_idx == LAST_OUTLINE);
            unique case (r_idx)
                3'd0: begin s_xs = cx_p_ox; s_y = cy_p_oy; end
                3'd1: begin s_xs = cx_p_oy; s_y = cy_p_ox; end
                3'd2: begin s_xs = cx_m_ox; s_y = cy_p_oy; end
                3'd3: begin s_xs = cx_m_oy; s_y = cy_p_ox; end
                3'd4: begin s_xs = cx_p_ox; s_y = cy_m_oy; end
                3'd5: begin s_xs = cx_p_oy; s_y = cy_m_ox; end
                3'd6: begin s_xs = cx_m_ox; s_y = cy_m_oy; end
                default: begin s_xs = cx_m_oy; s_y = cy_m_ox; end
            endcase
            s_xe = s_xs;
        end
    end

    assign out_load = !r_ovalid || !i_stall;
    assign emit     = r_active && out_load;
    // A new job is taken in the cycle the previous one hands over its last result.
    assign o_pop    = !i_stat.empty && (!r_active || (emit && s_last));

    always_comb begin
        n_job    = r_job;
        n_active = r_active;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = emit;
        end
        if (emit) begin
            n_idx = r_idx + IDX_BITS'(1);
            if (s_last) begin
                n_active = 1'b0;
            end
        end
        if (o_pop) begin
            n_job    = i_job;
            n_active = 1'b1;
            n_idx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (emit) begin
            r_xs    <= s_xs;
            r_xe    <= s_xe;
            r_y     <= s_y;
            r_color <= r_job.color;
            r_last  <= s_last;
            r_done  <= s_last && r_job.done;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_span_x_start = r_xs;
    assign o_span_x_end   = r_xe;
    assign o_span_y       = r_y;
    assign o_pixel_color  = r_color;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

endmodule

// File: src/circle_rasterizer.sv
// Top level of the circle rasteriser: front end, job queue and back end.
// Depends on crast_pkg, crast_front, crast_queue and crast_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  items   | in        | i_valid / o_stall  | action, centre x/y, radius, filled, colour
//  results | out       | o_valid / i_stall  | span x start/end, span y, colour, flags
//
// A load is taken and gives no result. A step is taken and queued; the back
// end then sends 8 outline points or 4 filled spans, one per cycle while the
// result side does not stall, through the single output register.
// Reset is synchronous and active low and clears all control state.
// o_stall rises only when the two-entry job queue is full; a stall on the
// result side holds the output register and backs up into that queue.
`timescale 1ns / 1ps

module circle_rasterizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic signed [crast_pkg::COORD_BITS-1:0] i_center_x,
    input  logic signed [crast_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [crast_pkg::RADIUS_BITS-1:0]    i_radius,
    input  logic                                 i_filled,
    input  logic [crast_pkg::COLOR_BITS-1:0]     i_color,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_x_start,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_x_end,
    output logic signed [crast_pkg::OUT_BITS-1:0] o_span_y,
    output logic [crast_pkg::COLOR_BITS-1:0]     o_pixel_color,
    output logic                                 o_last_of_step,
    output logic                                 o_circle_done
);
    import crast_pkg::*;

    logic    accept;
    logic    push, pop;
    t_job    push_job, head_job;
    t_q_stat q_stat;

    assign o_stall = q_stat.full;
    assign accept  = i_valid && !o_stall;

    crast_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_filled   (i_filled),
        .i_color    (i_color),
        .o_push     (push),
        .o_job      (push_job)
    );

    crast_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    crast_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_stat         (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span_x_start (o_span_x_start),
        .o_span_x_end   (o_span_x_end),
        .o_span_y       (o_span_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full && !pop))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("job popped from an empty queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_circle_done) |-> o_last_of_step)
        else $error("circle finished on a result that does not end its step");

    a_push_shows_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty right after a push");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for circle_rasterizer: directed and random circles,
// outline and filled, checked span by span against a built-in predictor.
// Depends on crast_pkg and the circle_rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import crast_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic signed [OUT_BITS-1:0] xs;
        logic signed [OUT_BITS-1:0] xe;
        logic signed [OUT_BITS-1:0] y;
        logic [COLOR_BITS-1:0]      color;
        logic                       last;
        logic                       done;
    } t_span;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    logic                           i_action   = 1'b0;
    logic signed [COORD_BITS-1:0]   i_center_x = '0;
    logic signed [COORD_BITS-1:0]   i_center_y = '0;
    logic [RADIUS_BITS-1:0]         i_radius   = '0;
    logic                           i_filled   = 1'b0;
    logic [COLOR_BITS-1:0]          i_color    = '0;
    logic                           o_valid;
    logic                           i_stall    = 1'b0;
    logic signed [OUT_BITS-1:0]     o_span_x_start;
    logic signed [OUT_BITS-1:0]     o_span_x_end;
    logic signed [OUT_BITS-1:0]     o_span_y;
    logic [COLOR_BITS-1:0]          o_pixel_color;
    logic                           o_last_of_step;
    logic                           o_circle_done;

    // Predictor state: the circle being drawn and its loop variables.
    bit                             circ_busy   = 1'b0;
    int                             circ_cx     = 0;
    int                             circ_cy     = 0;
    int                             circ_r      = 0;
    bit                             circ_filled = 1'b0;
    logic [COLOR_BITS-1:0]          circ_color  = '0;
    int                             off_x       = 0;
    int                             off_y       = 0;
    int                             circ_dec    = 0;

    t_span                          expected_spans[$];
    int unsigned                    send_idle_pct = 0;
    int unsigned                    recv_idle_pct = 0;
    int                             fail_count    = 0;
    int                             work_items    = 0;
    int                             loads_sent    = 0;
    int                             spans_checked = 0;
    int                             circles_done  = 0;
    int                             cycle_count   = 0;
    logic                           hold_go       = 1'b0;
    logic                           hold_ack      = 1'b0;
    int                             hold_left     = 0;

    circle_rasterizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_filled       (i_filled),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span_x_start (o_span_x_start),
        .o_span_x_end   (o_span_x_end),
        .o_span_y       (o_span_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= TIMEOUT_CYCLES);
        $display("Timeout after %0d cycles, %0d spans still expected",
                 cycle_count, expected_spans.size());
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_go != hold_ack) begin
            hold_ack  <= hold_go;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_span span_at(input int xs, input int xe, input int y);
        t_span s;
        s.xs    = OUT_BITS'(xs);
        s.xe    = OUT_BITS'(xe);
        s.y     = OUT_BITS'(y);
        s.color = circ_color;
        s.last  = 1'b0;
        s.done  = 1'b0;
        return s;
    endfunction

    // Works out the spans one accepted item produces and queues them.
    task automatic rasterize_item(input t_action act,
                                  input logic signed [COORD_BITS-1:0] cx_in,
                                  input logic signed [COORD_BITS-1:0] cy_in,
                                  input logic [RADIUS_BITS-1:0] rad_in,
                                  input logic fill_in,
                                  input logic [COLOR_BITS-1:0] col_in);
        int    cx;
        int    cy;
        int    ox;
        int    oy;
        int    n;
        t_span pts[8];
        if (act == ACT_LOAD) begin
            circ_cx     = int'(cx_in);
            circ_cy     = int'(cy_in);
            circ_r      = int'(rad_in);
            circ_filled = fill_in;
            circ_color  = col_in;
            off_x       = 0;
            off_y       = circ_r;
            circ_dec    = circ_r - 1;
            circ_busy   = 1'b1;
            work_items++;
            loads_sent++;
            return;
        end
        // A step with no circle loaded is dropped by the block.
        if (!circ_busy)
            return;
        work_items++;
        cx = circ_cx;
        cy = circ_cy;
        ox = off_x;
        oy = off_y;
        if (circ_filled) begin
            pts[0] = span_at(cx - oy, cx + oy, cy + ox);
            pts[1] = span_at(cx - ox, cx + ox, cy + oy);
            pts[2] = span_at(cx - ox, cx + ox, cy - oy);
            pts[3] = span_at(cx - oy, cx + oy, cy - ox);
            n = 4;
        end else begin
            pts[0] = span_at(cx + ox, cx + ox, cy + oy);
            pts[1] = span_at(cx + oy, cx + oy, cy + ox);
            pts[2] = span_at(cx - ox, cx - ox, cy + oy);
            pts[3] = span_at(cx - oy, cx - oy, cy + ox);
            pts[4] = span_at(cx + ox, cx + ox, cy - oy);
            pts[5] = span_at(cx + oy, cx + oy, cy - ox);
            pts[6] = span_at(cx - ox, cx - ox, cy - oy);
            pts[7] = span_at(cx - oy, cx - oy, cy - ox);
            n = 8;
        end
        if (circ_dec >= 2 * ox) begin
            circ_dec -= 2 * ox + 1;
            off_x = ox + 1;
        end else if (circ_dec < 2 * (circ_r - oy)) begin
            circ_dec += 2 * oy - 1;
            off_y = oy - 1;
        end else begin
            circ_dec += 2 * (oy - ox - 1);
            off_y = oy - 1;
            off_x = ox + 1;
        end
        pts[n-1].last = 1'b1;
        if (off_y < off_x) begin
            circ_busy     = 1'b0;
            pts[n-1].done = 1'b1;
            circles_done++;
        end
        for (int k = 0; k < n; k++)
            expected_spans.push_back(pts[k]);
    endtask

    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_spans.size() == 0) begin
                $error("Unexpected span transfer: x %0d..%0d, y %0d",
                       o_span_x_start, o_span_x_end, o_span_y);
                fail_count++;
            end else begin
                want = expected_spans.pop_front();
                spans_checked++;
                if (o_span_x_start !== want.xs) begin
                    $error("span_x_start: expected %0d, got %0d", want.xs, o_span_x_start);
                    fail_count++;
                end
                if (o_span_x_end !== want.xe) begin
                    $error("span_x_end: expected %0d, got %0d", want.xe, o_span_x_end);
                    fail_count++;
                end
                if (o_span_y !== want.y) begin
                    $error("span_y: expected %0d, got %0d", want.y, o_span_y);
                    fail_count++;
                end
                if (o_pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, o_pixel_color);
                    fail_count++;
                end
                if (o_last_of_step !== want.last) begin
                    $error("last_of_step: expected %0b, got %0b", want.last, o_last_of_step);
                    fail_count++;
                end
                if (o_circle_done !== want.done) begin
                    $error("circle_done: expected %0b, got %0b", want.done, o_circle_done);
                    fail_count++;
                end
            end
        end
    end

    // Offers one item and returns in the time step of its transfer, with
    // valid still high so that a following item can go out back to back.
    task automatic send_item(input t_action act,
                             input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [RADIUS_BITS-1:0] rad,
                             input logic fill,
                             input logic [COLOR_BITS-1:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        i_filled   <= fill;
        i_color    <= col;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        rasterize_item(act, cx, cy, rad, fill, col);
    endtask

    task automatic step_once();
        // The load-only fields carry noise on a step; the block must ignore them.
        send_item(ACT_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RADIUS_BITS'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic load_random(input int rad);
        send_item(ACT_LOAD, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RADIUS_BITS'(rad), 1'($urandom), $urandom);
    endtask

    task automatic finish_circle();
        while (circ_busy)
            step_once();
    endtask

    task automatic test_idle_step();
        step_once();
    endtask

    task automatic test_zero_radius();
        send_item(ACT_LOAD, '0, '0, '0, 1'b0, 32'h1234_5678);
        step_once();
        send_item(ACT_LOAD, -COORD_BITS'(2048), COORD_BITS'(2047), '0, 1'b1, 32'hFFFF_FFFF);
        step_once();
        // The circle has finished, so this step is dropped.
        step_once();
    endtask

    task automatic test_extreme_radius();
        send_item(ACT_LOAD, COORD_BITS'(2047), -COORD_BITS'(2048), RADIUS_BITS'(2047),
                  1'b0, 32'h0000_0000);
        step_once();
        step_once();
        send_item(ACT_LOAD, -COORD_BITS'(2048), COORD_BITS'(2047), RADIUS_BITS'(2047),
                  1'b1, 32'hA5A5_5A5A);
        step_once();
        step_once();
    endtask

    task automatic test_abandon();
        send_item(ACT_LOAD, COORD_BITS'(-7), COORD_BITS'(9), RADIUS_BITS'(5), 1'b0,
                  32'h0F0F_0F0F);
        step_once();
        send_item(ACT_LOAD, COORD_BITS'(100), COORD_BITS'(-100), RADIUS_BITS'(1), 1'b1,
                  32'hF0F0_F0F0);
        finish_circle();
    endtask

    task automatic test_small_outline();
        send_item(ACT_LOAD, COORD_BITS'(3), COORD_BITS'(-3), RADIUS_BITS'(2), 1'b0,
                  32'h8000_0001);
        finish_circle();
    endtask

    task automatic test_random_circles(input int target);
        int stop_at;
        int kind;
        int steps_left;
        stop_at = work_items + target;
        while (work_items < stop_at) begin
            kind = int'($urandom_range(99));
            if (kind < 70) begin
                // Mostly complete circles of small radius; now and then one is cut short.
                load_random(($urandom_range(9) == 0) ? int'($urandom_range(40))
                                                      : int'($urandom_range(12)));
                steps_left = ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : 1 << 20;
                while (circ_busy && steps_left > 0) begin
                    step_once();
                    steps_left--;
                end
            end else if (kind < 85) begin
                load_random(int'($urandom_range(2047)));
                repeat ($urandom_range(1, 6)) step_once();
            end else if (kind < 95) begin
                step_once();
            end else begin
                load_random(int'($urandom_range(12)));
                load_random(int'($urandom_range(12)));
            end
        end
    endtask

    // The result side holds off for a long stretch while steps keep coming,
    // so the job queue fills and the input channel must stall.
    task automatic test_backpressure();
        hold_go <= ~hold_go;
        send_item(ACT_LOAD, COORD_BITS'(-300), COORD_BITS'(250), RADIUS_BITS'(400), 1'b0,
                  32'hC0FF_EE00);
        repeat (12) step_once();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 71;
        test_idle_step();
        test_zero_radius();
        test_extreme_radius();
        test_abandon();
        test_small_outline();
        test_random_circles(40);

        send_idle_pct = 71;
        recv_idle_pct = 33;
        test_backpressure();
        test_random_circles(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_circles(40);
        drain_results();

        $display("Covered %0d working items (%0d loads, %0d circles finished) and %0d spans,",
                 work_items, loads_sent, circles_done, spans_checked);
        $display("outline and filled, radii 0 to 2047, abandoned circles and long back-pressure.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
